// ===== hw/rtl/e2c_pkg.sv =====
// package for the equirectangular to cube map address core
// field widths, fixed point constants, face and register codes, the arctangent table
// no dependencies
`timescale 1ns / 1ps

package e2c_pkg;

  localparam int SIZE_W       = 11;
  localparam int COORD_W      = 10;
  localparam int FACE_W       = 3;
  localparam int INDEX_W      = 20;
  localparam int CFG_IDX_W    = 1;
  localparam int MAX_SIZE     = 1024;

  localparam int DIV_STEPS    = 17;
  localparam int QUO_W        = 17;
  localparam int UV_W         = 18;
  localparam int ONE_BITS     = 16;
  localparam int DYG_W        = 18;
  localparam int ANG_W        = 20;
  localparam int TURN_BITS    = 18;
  localparam int HALF_BITS    = 17;
  localparam int CORDIC_ITERS = 16;

  localparam logic signed [UV_W-1:0]  ONE_Q16      = 18'sd65536;
  localparam logic signed [UV_W-1:0]  GAIN_Q16     = 18'sd107922;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 20'sd131072;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 20'sd65536;

  localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
  localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
  localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = 11'd1024;
  localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = 11'd512;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } pix_t;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [QUO_W-1:0]  qu;
    logic [QUO_W-1:0]  qv;
  } quo_t;

  typedef struct packed {
    logic                    bad;
    logic signed [DYG_W-1:0] dyg;
  } c1_side_t;

  typedef struct packed {
    logic                    bad;
    logic signed [ANG_W-1:0] phi;
  } c2_side_t;

  // round(atan(2^-i) / 2pi * 2^18)
  function automatic logic [ANG_W-1:0] atan_entry(input int i);
    logic [ANG_W-1:0] a;
    case (i)
      0:  a = 20'd32768;
      1:  a = 20'd19344;
      2:  a = 20'd10221;
      3:  a = 20'd5188;
      4:  a = 20'd2604;
      5:  a = 20'd1303;
      6:  a = 20'd652;
      7:  a = 20'd326;
      8:  a = 20'd163;
      9:  a = 20'd81;
      10: a = 20'd41;
      11: a = 20'd20;
      12: a = 20'd10;
      13: a = 20'd5;
      14: a = 20'd3;
      15: a = 20'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/e2c_dest_if.sv =====
// channel carrying one cube face pixel word
// depends on e2c_pkg
`timescale 1ns / 1ps

interface e2c_dest_if;
  logic                        valid;
  logic                        ready;
  logic [e2c_pkg::FACE_W-1:0]  face;
  logic [e2c_pkg::COORD_W-1:0] dest_x;
  logic [e2c_pkg::COORD_W-1:0] dest_y;

  modport source (output valid, face, dest_x, dest_y, input ready);
  modport sink (input valid, face, dest_x, dest_y, output ready);
endinterface

// ===== hw/rtl/e2c_src_if.sv =====
// channel carrying one source address word
// depends on e2c_pkg
`timescale 1ns / 1ps

interface e2c_src_if;
  logic                        valid;
  logic                        ready;
  logic [e2c_pkg::COORD_W-1:0] src_x;
  logic [e2c_pkg::COORD_W-1:0] src_y;
  logic [e2c_pkg::INDEX_W-1:0] src_index;

  modport source (output valid, src_x, src_y, src_index, input ready);
  modport sink (input valid, src_x, src_y, src_index, output ready);
endinterface

// ===== hw/rtl/e2c_uv.sv =====
// pipelined restoring divider forming floor((2x+1)*2^16/N) for both face coordinates
// depends on e2c_pkg
`timescale 1ns / 1ps

module e2c_uv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [e2c_pkg::SIZE_W-1:0]  h,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  e2c_pkg::pix_t               in_pix,
  output logic                        out_valid,
  input  logic                        out_ready,
  output e2c_pkg::quo_t               out_quo
);
  localparam int PER = 3;
  localparam int NST = (e2c_pkg::DIV_STEPS + PER - 1) / PER;
  localparam int RW  = e2c_pkg::SIZE_W;
  localparam int QW  = e2c_pkg::QUO_W;

  typedef struct packed {
    logic [e2c_pkg::FACE_W-1:0] face;
    logic [RW-1:0]              rx;
    logic [RW-1:0]              ry;
    logic [QW-1:0]              qx;
    logic [QW-1:0]              qy;
  } div_t;

  function automatic div_t div_steps(input div_t s, input logic [RW-1:0] d, input int first);
    div_t      r;
    logic [RW:0] t;
    r = s;
    for (int j = 0; j < PER; j++) begin
      if (first + j < e2c_pkg::DIV_STEPS) begin
        // the numerator has a single one bit at the first step
        t = {r.rx, 1'(first + j == 0)};
        if (t >= {1'b0, d}) begin
          r.rx = RW'(t - {1'b0, d});
          r.qx = {r.qx[QW-2:0], 1'b1};
        end else begin
          r.rx = t[RW-1:0];
          r.qx = {r.qx[QW-2:0], 1'b0};
        end
        t = {r.ry, 1'(first + j == 0)};
        if (t >= {1'b0, d}) begin
          r.ry = RW'(t - {1'b0, d});
          r.qy = {r.qy[QW-2:0], 1'b1};
        end else begin
          r.ry = t[RW-1:0];
          r.qy = {r.qy[QW-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  logic [NST-1:0] vld;
  logic [NST-1:0] v_src;
  logic [NST:0]   rdy;
  div_t           st  [NST];
  div_t           src [NST];
  div_t           nxt [NST];
  logic [RW-1:0]  hm1;
  logic [RW-1:0]  x_sat;
  logic [RW-1:0]  y_sat;

  assign hm1   = h - RW'(1);
  assign x_sat = (RW'(in_pix.dest_x) > hm1) ? hm1 : RW'(in_pix.dest_x);
  assign y_sat = (RW'(in_pix.dest_y) > hm1) ? hm1 : RW'(in_pix.dest_y);

  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_comb begin
    src[0]   = '{face: in_pix.face, rx: x_sat, ry: y_sat, qx: '0, qy: '0};
    v_src[0] = in_valid;
    for (int k = 1; k < NST; k++) begin
      src[k]   = st[k-1];
      v_src[k] = vld[k-1];
    end
    for (int k = 0; k < NST; k++) begin
      nxt[k] = div_steps(src[k], h, k * PER);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= v_src[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];
  assign out_quo   = '{face: st[NST-1].face, qu: st[NST-1].qx, qv: st[NST-1].qy};

endmodule

// ===== hw/rtl/e2c_dir.sv =====
// face direction vector from the coordinate quotients, and the gain scaled y component
// depends on e2c_pkg
`timescale 1ns / 1ps

module e2c_dir (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  e2c_pkg::quo_t                     in_quo,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [e2c_pkg::UV_W-1:0]   out_dx,
  output logic signed [e2c_pkg::UV_W-1:0]   out_dz,
  output e2c_pkg::c1_side_t                 out_side
);
  localparam int UW = e2c_pkg::UV_W;

  logic [1:0]             vld;
  logic [2:0]             rdy;
  logic signed [UW-1:0]   u;
  logic signed [UW-1:0]   v;
  logic signed [UW-1:0]   dx_n;
  logic signed [UW-1:0]   dy_n;
  logic signed [UW-1:0]   dz_n;
  logic                   bad_n;
  logic signed [UW-1:0]   dx0;
  logic signed [UW-1:0]   dy0;
  logic signed [UW-1:0]   dz0;
  logic                   bad0;
  logic signed [UW-1:0]   dx1;
  logic signed [UW-1:0]   dz1;
  logic                   bad1;
  logic signed [2*UW-1:0] prod1;

  always_comb begin
    rdy[2] = out_ready;
    rdy[1] = !vld[1] || rdy[2];
    rdy[0] = !vld[0] || rdy[1];
  end

  assign u = $signed(UW'(in_quo.qu)) - e2c_pkg::ONE_Q16;
  assign v = e2c_pkg::ONE_Q16 - $signed(UW'(in_quo.qv));

  always_comb begin
    dx_n  = '0;
    dy_n  = '0;
    dz_n  = '0;
    bad_n = 1'b0;
    case (in_quo.face)
      e2c_pkg::FACE_POS_X: begin
        dx_n = e2c_pkg::ONE_Q16;
        dy_n = v;
        dz_n = -u;
      end
      e2c_pkg::FACE_NEG_X: begin
        dx_n = -e2c_pkg::ONE_Q16;
        dy_n = v;
        dz_n = u;
      end
      e2c_pkg::FACE_POS_Y: begin
        dx_n = u;
        dy_n = e2c_pkg::ONE_Q16;
        dz_n = -v;
      end
      e2c_pkg::FACE_NEG_Y: begin
        dx_n = u;
        dy_n = -e2c_pkg::ONE_Q16;
        dz_n = v;
      end
      e2c_pkg::FACE_POS_Z: begin
        dx_n = u;
        dy_n = v;
        dz_n = e2c_pkg::ONE_Q16;
      end
      e2c_pkg::FACE_NEG_Z: begin
        dx_n = -u;
        dy_n = v;
        dz_n = -e2c_pkg::ONE_Q16;
      end
      default: begin
        bad_n = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      if (rdy[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx0  <= dx_n;
      dy0  <= dy_n;
      dz0  <= dz_n;
      bad0 <= bad_n;
    end
    if (rdy[1]) begin
      dx1   <= dx0;
      dz1   <= dz0;
      bad1  <= bad0;
      prod1 <= dy0 * e2c_pkg::GAIN_Q16;
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = vld[1];
  assign out_dx        = dx1;
  assign out_dz        = dz1;
  assign out_side.bad  = bad1;
  assign out_side.dyg  = prod1[e2c_pkg::ONE_BITS + e2c_pkg::DYG_W - 1:e2c_pkg::ONE_BITS];

endmodule

// ===== hw/rtl/e2c_cordic.sv =====
// pipelined cordic vectoring unit, half turn prerotation then four iterations per stage
// depends on e2c_pkg
`timescale 1ns / 1ps

module e2c_cordic #(
  parameter int  IN_W   = 18,
  parameter int  XY_W   = 20,
  parameter type SIDE_T = logic
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [IN_W-1:0]            in_x,
  input  logic signed [IN_W-1:0]            in_y,
  input  SIDE_T                             in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [e2c_pkg::ANG_W-1:0]  out_ang,
  output logic signed [XY_W-1:0]            out_mag,
  output SIDE_T                             out_side
);
  localparam int PER = 4;
  localparam int NST = 1 + e2c_pkg::CORDIC_ITERS / PER;
  localparam int AW  = e2c_pkg::ANG_W;

  typedef struct packed {
    logic                 zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [AW-1:0]   z;
    SIDE_T                side;
  } cst_t;

  function automatic cst_t pre_rot(input logic signed [IN_W-1:0] x, input logic signed [IN_W-1:0] y,
                                   input SIDE_T side);
    cst_t r;
    r.side = side;
    r.zero = (x == '0) && (y == '0);
    r.x    = XY_W'(x);
    r.y    = XY_W'(y);
    r.z    = '0;
    if (x[IN_W-1]) begin
      r.z = !y[IN_W-1] ? e2c_pkg::HALF_TURN : -e2c_pkg::HALF_TURN;
      r.x = -r.x;
      r.y = -r.y;
    end
    return r;
  endfunction

  function automatic cst_t rot_steps(input cst_t s, input int first);
    cst_t                 r;
    logic signed [XY_W-1:0] xv;
    logic signed [XY_W-1:0] yv;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [AW-1:0]   zv;
    r  = s;
    xv = s.x;
    yv = s.y;
    zv = s.z;
    for (int j = 0; j < PER; j++) begin
      xs = xv >>> (first + j);
      ys = yv >>> (first + j);
      if (!yv[XY_W-1]) begin
        xv = xv + ys;
        yv = yv - xs;
        zv = zv + $signed(e2c_pkg::atan_entry(first + j));
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        zv = zv - $signed(e2c_pkg::atan_entry(first + j));
      end
    end
    r.x = xv;
    r.y = yv;
    r.z = zv;
    return r;
  endfunction

  logic [NST-1:0] vld;
  logic [NST-1:0] v_src;
  logic [NST:0]   rdy;
  cst_t           st  [NST];
  cst_t           nxt [NST];

  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_comb begin
    nxt[0]   = pre_rot(in_x, in_y, in_side);
    v_src[0] = in_valid;
    for (int k = 1; k < NST; k++) begin
      nxt[k]   = rot_steps(st[k-1], (k - 1) * PER);
      v_src[k] = vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          vld[k] <= v_src[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (rdy[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  // zero vector in gives angle zero
  assign in_ready  = rdy[0];
  assign out_valid = vld[NST-1];
  assign out_ang   = st[NST-1].zero ? '0 : st[NST-1].z;
  assign out_mag   = st[NST-1].x;
  assign out_side  = st[NST-1].side;

endmodule

// ===== hw/rtl/e2c_map.sv =====
// maps the two angles to clamped source column and row, then the linear index
// depends on e2c_pkg
`timescale 1ns / 1ps

module e2c_map (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [e2c_pkg::SIZE_W-1:0]        w,
  input  logic [e2c_pkg::SIZE_W-1:0]        h,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [e2c_pkg::ANG_W-1:0]  in_theta,
  input  e2c_pkg::c2_side_t                 in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [e2c_pkg::COORD_W-1:0]       out_x,
  output logic [e2c_pkg::COORD_W-1:0]       out_y,
  output logic [e2c_pkg::INDEX_W-1:0]       out_index
);
  localparam int SW   = e2c_pkg::SIZE_W;
  localparam int AW   = e2c_pkg::ANG_W;
  localparam int PA_W = AW + 1;
  localparam int PC_W = PA_W + SW + 1;
  localparam int PR_W = AW + SW + 1;
  localparam int CS_W = PC_W - e2c_pkg::TURN_BITS;
  localparam int RS_W = PR_W - e2c_pkg::HALF_BITS;
  localparam int PI_W = 2 * SW;

  logic [3:0]             vld;
  logic [4:0]             rdy;
  logic signed [AW-1:0]   ph;
  logic signed [AW-1:0]   th;
  logic signed [PA_W-1:0] pa;
  logic signed [PC_W-1:0] pc;
  logic signed [PR_W-1:0] pr;
  logic [SW-1:0]          wm1;
  logic [SW-1:0]          hm1;
  logic [CS_W-1:0]        cs;
  logic [RS_W-1:0]        rs;
  logic [SW-1:0]          col_n;
  logic [SW-1:0]          row_n;
  logic [SW-1:0]          col1;
  logic [SW-1:0]          row1;
  logic [SW-1:0]          col2;
  logic [SW-1:0]          row2;
  logic [PI_W-1:0]        pi2;
  logic [e2c_pkg::COORD_W-1:0] sx3;
  logic [e2c_pkg::COORD_W-1:0] sy3;
  logic [e2c_pkg::INDEX_W-1:0] idx3;

  always_comb begin
    rdy[4] = out_ready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  // unknown face code: phi zero, theta a quarter turn
  assign ph  = in_side.bad ? '0 : in_side.phi;
  assign th  = in_side.bad ? e2c_pkg::QUARTER_TURN : in_theta;
  assign pa  = PA_W'(ph) + PA_W'(e2c_pkg::HALF_TURN);
  assign wm1 = w - SW'(1);
  assign hm1 = h - SW'(1);
  assign cs  = pc[PC_W-1:e2c_pkg::TURN_BITS];
  assign rs  = pr[PR_W-1:e2c_pkg::HALF_BITS];

  always_comb begin
    if (pc[PC_W-1]) begin
      col_n = '0;
    end else if (cs > CS_W'(wm1)) begin
      col_n = wm1;
    end else begin
      col_n = cs[SW-1:0];
    end
    if (pr[PR_W-1]) begin
      row_n = '0;
    end else if (rs > RS_W'(hm1)) begin
      row_n = hm1;
    end else begin
      row_n = rs[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < 4; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pc <= pa * $signed({1'b0, w});
      pr <= th * $signed({1'b0, h});
    end
    if (rdy[1]) begin
      col1 <= col_n;
      row1 <= row_n;
    end
    if (rdy[2]) begin
      col2 <= col1;
      row2 <= row1;
      pi2  <= row1 * w;
    end
    if (rdy[3]) begin
      sx3  <= col2[e2c_pkg::COORD_W-1:0];
      sy3  <= row2[e2c_pkg::COORD_W-1:0];
      idx3 <= e2c_pkg::INDEX_W'(pi2 + PI_W'(col2));
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[3];
  assign out_x     = sx3;
  assign out_y     = sy3;
  assign out_index = idx3;

endmodule

// ===== hw/rtl/equirect_to_cubemap_address_core.sv =====
// Nearest-sample address generator from cube map face pixels into an equirectangular
// source image. One pixel word is taken and one address word given per clock when the
// result side keeps up. There are 6 divider stages for the face coordinates, 2 for the
// direction vector and its gain product, 5 for each of the two cordic units and 4 for
// mapping, clamping and the index multiply. Every stage holds its own valid bit, so a
// stall on the result side only holds words, and bubbles are squeezed out. src_width and
// src_height are to be written only while the block is empty; the block does not enforce
// it. 0 acts as 1, values above MAX_SIZE act as MAX_SIZE; src_height is also the face edge size.
// depends on e2c_pkg, e2c_dest_if, e2c_src_if, e2c_uv, e2c_dir, e2c_cordic, e2c_map
`timescale 1ns / 1ps

module equirect_to_cubemap_address_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [e2c_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [e2c_pkg::SIZE_W-1:0]     cfg_data,
  e2c_dest_if.sink                       dest,
  e2c_src_if.source                      src
);
  localparam int SW   = e2c_pkg::SIZE_W;
  localparam int C1_W = 20;
  localparam int C2_W = 21;

  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] r);
    logic [SW-1:0] s;
    if (r == '0) begin
      s = SW'(1);
    end else if (int'(r) > e2c_pkg::MAX_SIZE) begin
      s = SW'(e2c_pkg::MAX_SIZE);
    end else begin
      s = r;
    end
    return s;
  endfunction

  logic [SW-1:0] src_width;
  logic [SW-1:0] src_height;
  logic [SW-1:0] w_eff;
  logic [SW-1:0] h_eff;

  e2c_pkg::pix_t pix;

  logic                  uv_valid;
  logic                  uv_ready;
  e2c_pkg::quo_t         quo;

  logic                             dir_valid;
  logic                             dir_ready;
  logic signed [e2c_pkg::UV_W-1:0]  dx;
  logic signed [e2c_pkg::UV_W-1:0]  dz;
  e2c_pkg::c1_side_t                c1_side;

  logic                              c1_valid;
  logic                              c1_ready;
  logic signed [e2c_pkg::ANG_W-1:0]  phi;
  logic signed [C1_W-1:0]            mag;
  e2c_pkg::c1_side_t                 c1_out;
  e2c_pkg::c2_side_t                 c2_side;

  logic                              c2_valid;
  logic                              c2_ready;
  logic signed [e2c_pkg::ANG_W-1:0]  theta;
  e2c_pkg::c2_side_t                 c2_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= e2c_pkg::SRC_WIDTH_RST;
      src_height <= e2c_pkg::SRC_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        e2c_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
        e2c_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = eff_size(src_width);
  assign h_eff = eff_size(src_height);

  assign pix = '{face: dest.face, dest_x: dest.dest_x, dest_y: dest.dest_y};

  e2c_uv u_uv (
    .clk       (clk),
    .rst       (rst),
    .h         (h_eff),
    .in_valid  (dest.valid),
    .in_ready  (dest.ready),
    .in_pix    (pix),
    .out_valid (uv_valid),
    .out_ready (uv_ready),
    .out_quo   (quo)
  );

  e2c_dir u_dir (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (uv_valid),
    .in_ready  (uv_ready),
    .in_quo    (quo),
    .out_valid (dir_valid),
    .out_ready (dir_ready),
    .out_dx    (dx),
    .out_dz    (dz),
    .out_side  (c1_side)
  );

  // longitude from (dz, dx)
  e2c_cordic #(
    .IN_W   (e2c_pkg::UV_W),
    .XY_W   (C1_W),
    .SIDE_T (e2c_pkg::c1_side_t)
  ) u_cordic_lon (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dir_valid),
    .in_ready  (dir_ready),
    .in_x      (dz),
    .in_y      (dx),
    .in_side   (c1_side),
    .out_valid (c1_valid),
    .out_ready (c1_ready),
    .out_ang   (phi),
    .out_mag   (mag),
    .out_side  (c1_out)
  );

  assign c2_side = '{bad: c1_out.bad, phi: phi};

  // polar angle from (gain scaled dy, horizontal magnitude)
  e2c_cordic #(
    .IN_W   (C1_W),
    .XY_W   (C2_W),
    .SIDE_T (e2c_pkg::c2_side_t)
  ) u_cordic_pol (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c1_valid),
    .in_ready  (c1_ready),
    .in_x      (C1_W'(c1_out.dyg)),
    .in_y      (mag),
    .in_side   (c2_side),
    .out_valid (c2_valid),
    .out_ready (c2_ready),
    .out_ang   (theta),
    .out_mag   (),
    .out_side  (c2_out)
  );

  e2c_map u_map (
    .clk       (clk),
    .rst       (rst),
    .w         (w_eff),
    .h         (h_eff),
    .in_valid  (c2_valid),
    .in_ready  (c2_ready),
    .in_theta  (theta),
    .in_side   (c2_out),
    .out_valid (src.valid),
    .out_ready (src.ready),
    .out_x     (src.src_x),
    .out_y     (src.src_y),
    .out_index (src.src_index)
  );

endmodule

// ===== sim/tb_equirect_to_cubemap_address_core.sv =====
// self-checking testbench for equirect_to_cubemap_address_core
// drives random and corner pixel words through several size settings and checks each address
// depends on e2c_pkg, e2c_dest_if, e2c_src_if and the core
`timescale 1ns / 1ps

module tb_equirect_to_cubemap_address_core;

  typedef struct {
    logic [e2c_pkg::COORD_W-1:0] col;
    logic [e2c_pkg::COORD_W-1:0] row;
    logic [e2c_pkg::INDEX_W-1:0] index;
  } addr_t;

  class addr_scoreboard;
    addr_t   pending_q[$];
    longint  width_reg;
    longint  height_reg;
    int      errors;

    function new();
      width_reg  = e2c_pkg::SRC_WIDTH_RST;
      height_reg = e2c_pkg::SRC_HEIGHT_RST;
      errors     = 0;
    endfunction

    function longint clip_size(longint r);
      if (r == 0) return 1;
      if (r > e2c_pkg::MAX_SIZE) return e2c_pkg::MAX_SIZE;
      return r;
    endfunction

    // vectoring rotation, returns angle and scaled magnitude
    function void rotate_to_axis(longint xi, longint yi, output longint ang, output longint mag);
      longint x, y, z, xs, ys;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0) begin
        ang = 0;
        mag = 0;
        return;
      end
      if (x < 0) begin
        z = (y >= 0) ? 131072 : -131072;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < e2c_pkg::CORDIC_ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(e2c_pkg::atan_entry(i));
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(e2c_pkg::atan_entry(i));
        end
      end
      ang = z;
      mag = x;
    endfunction

    function void note_pixel(logic [e2c_pkg::FACE_W-1:0] face,
                             logic [e2c_pkg::COORD_W-1:0] px,
                             logic [e2c_pkg::COORD_W-1:0] py);
      longint w, h, x, y, u, v, dx, dy, dz, phi, theta, mag, tmp, col, row;
      addr_t a;
      w = clip_size(width_reg);
      h = clip_size(height_reg);
      x = px;
      y = py;
      if (x > h - 1) x = h - 1;
      if (y > h - 1) y = h - 1;
      u = ((2 * x + 1) * 65536) / h - 65536;
      v = 65536 - ((2 * y + 1) * 65536) / h;
      dx = 0; dy = 0; dz = 0;
      case (face)
        e2c_pkg::FACE_POS_X: begin dx = 65536;  dy = v;      dz = -u;     end
        e2c_pkg::FACE_NEG_X: begin dx = -65536; dy = v;      dz = u;      end
        e2c_pkg::FACE_POS_Y: begin dx = u;      dy = 65536;  dz = -v;     end
        e2c_pkg::FACE_NEG_Y: begin dx = u;      dy = -65536; dz = v;      end
        e2c_pkg::FACE_POS_Z: begin dx = u;      dy = v;      dz = 65536;  end
        e2c_pkg::FACE_NEG_Z: begin dx = -u;     dy = v;      dz = -65536; end
        default: ;
      endcase
      if (face > e2c_pkg::FACE_NEG_Z) begin
        phi   = 0;
        theta = 65536;
      end else begin
        rotate_to_axis(dz, dx, phi, mag);
        rotate_to_axis((dy * 107922) >>> 16, mag, theta, tmp);
      end
      col = ((phi + 131072) * w) >>> 18;
      row = (theta * h) >>> 17;
      if (col < 0) col = 0;
      if (col > w - 1) col = w - 1;
      if (row < 0) row = 0;
      if (row > h - 1) row = h - 1;
      a.col   = col[e2c_pkg::COORD_W-1:0];
      a.row   = row[e2c_pkg::COORD_W-1:0];
      tmp     = row * w + col;
      a.index = tmp[e2c_pkg::INDEX_W-1:0];
      pending_q.push_back(a);
    endfunction

    function void check_addr(logic [e2c_pkg::COORD_W-1:0] col,
                             logic [e2c_pkg::COORD_W-1:0] row,
                             logic [e2c_pkg::INDEX_W-1:0] index);
      addr_t e;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected word x=%0d y=%0d index=%0d", $time, col, row, index);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (col !== e.col) begin
        $display("%0t src_x expected %0d actual %0d", $time, e.col, col);
        errors++;
      end
      if (row !== e.row) begin
        $display("%0t src_y expected %0d actual %0d", $time, e.row, row);
        errors++;
      end
      if (index !== e.index) begin
        $display("%0t src_index expected %0d actual %0d", $time, e.index, index);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [e2c_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [e2c_pkg::SIZE_W-1:0] cfg_data;
  int send_idle;
  int recv_idle;
  longint cycles = 0;
  addr_scoreboard sb;

  e2c_dest_if dest ();
  e2c_src_if  src ();

  equirect_to_cubemap_address_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dest      (dest),
    .src       (src)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    src.ready = ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && src.valid && src.ready) sb.check_addr(src.src_x, src.src_y, src.src_index);
  end

  task automatic write_reg(logic [e2c_pkg::CFG_IDX_W-1:0] idx,
                           logic [e2c_pkg::SIZE_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == e2c_pkg::REG_SRC_WIDTH) sb.width_reg = val;
    else sb.height_reg = val;
  endtask

  task automatic send_pixel(logic [e2c_pkg::FACE_W-1:0] face,
                            logic [e2c_pkg::COORD_W-1:0] x,
                            logic [e2c_pkg::COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle) begin
      dest.valid = 1'b0;
      @(negedge clk);
    end
    dest.valid  = 1'b1;
    dest.face   = face;
    dest.dest_x = x;
    dest.dest_y = y;
    do @(posedge clk); while (!dest.ready);
    sb.note_pixel(face, x, y);
    @(negedge clk);
  endtask

  task automatic drain();
    dest.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic random_pixel();
    logic [e2c_pkg::FACE_W-1:0] f;
    logic [e2c_pkg::COORD_W-1:0] x, y;
    longint h;
    h = sb.clip_size(sb.height_reg);
    f = ($urandom_range(19) == 0) ? e2c_pkg::FACE_W'($urandom_range(7)) :
                                    e2c_pkg::FACE_W'($urandom_range(5));
    if ($urandom_range(9) == 0) begin
      x = e2c_pkg::COORD_W'($urandom);
      y = e2c_pkg::COORD_W'($urandom);
    end else begin
      x = e2c_pkg::COORD_W'($urandom_range(int'(h - 1)));
      y = e2c_pkg::COORD_W'($urandom_range(int'(h - 1)));
    end
    send_pixel(f, x, y);
  endtask

  logic [e2c_pkg::SIZE_W-1:0] widths[8]  = '{11'd1024, 11'd0, 11'd1, 11'd2047, 11'd640,
                                              11'd1024, 11'd333, 11'd1024};
  logic [e2c_pkg::SIZE_W-1:0] heights[8] = '{11'd512, 11'd1024, 11'd3, 11'd0, 11'd2047,
                                              11'd1, 11'd257, 11'd1024};

  initial begin
    sb         = new();
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = e2c_pkg::REG_SRC_WIDTH;
    cfg_data   = '0;
    dest.valid = 1'b0;
    dest.face  = '0;
    dest.dest_x = '0;
    dest.dest_y = '0;
    send_idle  = 21;
    recv_idle  = 85;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corners of every face and the unused face codes at reset sizes
    for (int f = 0; f < 8; f++) begin
      send_pixel(e2c_pkg::FACE_W'(f), '0, '0);
      send_pixel(e2c_pkg::FACE_W'(f), 10'd1023, 10'd1023);
    end
    send_pixel(e2c_pkg::FACE_POS_Y, 10'd255, 10'd255);
    send_pixel(e2c_pkg::FACE_NEG_Y, 10'd256, 10'd256);
    send_pixel(e2c_pkg::FACE_POS_Z, 10'd1023, 10'd0);
    send_pixel(e2c_pkg::FACE_NEG_Z, 10'd0, 10'd1023);
    send_pixel(e2c_pkg::FACE_POS_X, 10'd511, 10'd256);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        send_idle = 85;
        recv_idle = 21;
      end else if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(e2c_pkg::REG_SRC_WIDTH, widths[p]);
      write_reg(e2c_pkg::REG_SRC_HEIGHT, heights[p]);
      // pole of the y faces for odd edge sizes
      send_pixel(e2c_pkg::FACE_POS_Y, heights[p][e2c_pkg::SIZE_W-1:1],
                 heights[p][e2c_pkg::SIZE_W-1:1]);
      send_pixel(e2c_pkg::FACE_NEG_Y, heights[p][e2c_pkg::SIZE_W-1:1],
                 heights[p][e2c_pkg::SIZE_W-1:1]);
      for (int i = 0; i < 105; i++) begin
        if (p == 4 && i == 50) begin
          dest.valid = 1'b0;
          while (sb.pending_q.size() != 0) @(negedge clk);
        end
        random_pixel();
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
